[src/bfsp_pkg.sv]
// Package: shared types, constants and state codes for the shortest-path block.
`default_nettype none
package bfsp_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam logic [6:0] NONE_PRED = 7'd64;
    localparam logic [47:0] DIST_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] DIST_MIN = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_RUN    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_SOURCE = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         edge_from;
        logic [5:0]         edge_to;
        logic signed [31:0] edge_cost;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         vertex;
        logic signed [47:0] distance;
        logic [6:0]         predecessor;
        logic               reachable;
        logic               status;
        logic [7:0]         cycle_edge;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EREAD,
        ST_FETCH,
        ST_RELAX,
        ST_PASS_END,
        ST_CYC_OUT,
        ST_ORD,
        ST_OSEND
    } t_state;

    // Result of the shared relax unit handed to the sequencer.
    typedef struct packed {
        logic               update;
        logic signed [47:0] sum;
    } t_relax;
endpackage
`default_nettype wire

[src/bfsp_relax.sv]
// Shared relaxation unit: saturating add of distance and cost, and compare.
`default_nettype none
module bfsp_relax
    import bfsp_pkg::*;
(
    input  wire logic               i_from_reached,
    input  wire logic               i_to_reached,
    input  wire logic               i_in_range,
    input  wire logic signed [47:0] i_dist_from,
    input  wire logic signed [47:0] i_dist_to,
    input  wire logic signed [31:0] i_cost,
    output t_relax                  o_res
);
    logic signed [48:0] sum_wide;
    logic signed [47:0] sum_sat;

    always_comb begin
        sum_wide = {i_dist_from[47], i_dist_from} + 49'(i_cost);
        if (sum_wide[48:47] == 2'b01) begin
            sum_sat = DIST_MAX;
        end else if (sum_wide[48:47] == 2'b10) begin
            sum_sat = DIST_MIN;
        end else begin
            sum_sat = sum_wide[47:0];
        end
        o_res.sum    = sum_sat;
        o_res.update = i_in_range && i_from_reached &&
                       (!i_to_reached || (i_dist_to > sum_sat));
    end
endmodule
`default_nettype wire

[src/bellman_ford_shortest_paths.sv]
// Top level: Bellman-Ford shortest paths with edge memory and a relax sequencer.
// Append and clear beats give no result. A run beat gives one result per vertex after
// at most n passes, n being vertex_count held to 1..MAX_VERTICES, or a single cycle
// report when the check pass finds a negative cycle; each pass sends every edge
// through the one shared relax unit. The input stalls until the last result is taken.
// Synchronous active-low reset clears edge count, source, reach marks and control, and sets vertex_count to 4.
`default_nettype none
module bellman_ford_shortest_paths
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // Edge memory: from, to and cost packed in one word.
    logic [43:0] edge_mem [MAX_EDGES];
    // Distance and predecessor memories, each written at one address a cycle.
    logic signed [47:0] dist_mem [MAX_VERTICES];
    logic [6:0] pred_mem [MAX_VERTICES];
    // Reach marks live in flip-flops so that a run can clear them at once.
    logic [MAX_VERTICES-1:0] r_reached;

    t_state r_state, n_state;
    logic [EW-1:0] r_total;
    logic [6:0] r_vcount;
    logic [5:0] r_source;
    logic [EW-1:0] r_eidx;
    logic [6:0] r_pass;
    logic r_changed;
    logic r_check;
    logic [6:0] r_vidx;
    logic [43:0] r_edge;
    logic signed [47:0] r_dfrom, r_dto;
    logic [6:0] r_pout;
    logic [6:0] r_n;
    t_out_item r_out;
    logic r_ovalid;

    logic in_acc;
    logic app_acc;
    logic src_ok;
    logic cyc_hit;
    logic out_load;
    logic last_vtx;
    logic pass_done;
    logic [5:0] e_from, e_to;
    logic signed [31:0] e_cost;
    logic [6:0] n_eff;
    logic [VA-1:0] rd_addr;
    t_relax rx;
    logic in_rng;

    // The input is held off while a run is busy and while a result beat waits.
    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign app_acc = in_acc && (i_item.action == ACT_APPEND) && (r_total < EW'(MAX_EDGES));
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;
    assign e_from = r_edge[43:38];
    assign e_to   = r_edge[37:32];
    assign e_cost = r_edge[31:0];
    assign in_rng = (7'(e_from) < r_n) && (7'(e_to) < r_n);
    assign src_ok = (7'(r_source) < r_n);
    // An edge that still relaxes in the check pass lies on a negative cycle.
    assign cyc_hit = (r_state == ST_RELAX) && r_check && rx.update;
    assign out_load = cyc_hit || ((r_state == ST_OSEND) && (!r_ovalid || !i_stall));
    assign last_vtx = (r_vidx + 7'd1 >= r_n);
    // The run ends after the check pass, after a pass with no change, or at once
    // when the table is empty, since a pass over no edges changes nothing.
    assign pass_done = r_check || !r_changed || (r_total == '0);
    // The second distance read port serves the edge target and the result sweep.
    assign rd_addr = (r_state == ST_ORD) ? r_vidx[VA-1:0] : e_to[VA-1:0];

    always_comb begin
        if (r_vcount == 7'd0) begin
            n_eff = 7'd1;
        end else if (r_vcount > 7'(MAX_VERTICES)) begin
            n_eff = 7'(MAX_VERTICES);
        end else begin
            n_eff = r_vcount;
        end
    end

    bfsp_relax u_relax (
        .i_from_reached (r_reached[e_from[VA-1:0]]),
        .i_to_reached   (r_reached[e_to[VA-1:0]]),
        .i_in_range     (in_rng),
        .i_dist_from    (r_dfrom),
        .i_dist_to      (r_dto),
        .i_cost         (e_cost),
        .o_res          (rx)
    );

    // Memory write and read ports.
    always_ff @(posedge i_clk) begin
        if (app_acc) begin
            edge_mem[r_total[EA-1:0]] <= {i_item.edge_from, i_item.edge_to, i_item.edge_cost};
        end
        r_edge <= edge_mem[r_eidx[EA-1:0]];
        if (r_state == ST_CLEAR && src_ok) begin
            // The source starts at distance zero with no predecessor.
            dist_mem[r_source[VA-1:0]] <= '0;
            pred_mem[r_source[VA-1:0]] <= NONE_PRED;
        end else if (r_state == ST_RELAX && rx.update) begin
            dist_mem[e_to[VA-1:0]] <= rx.sum;
            pred_mem[e_to[VA-1:0]] <= {1'b0, e_from};
        end
        if (r_state == ST_FETCH) begin
            r_dfrom <= dist_mem[e_from[VA-1:0]];
        end
        if (r_state == ST_FETCH || r_state == ST_ORD) begin
            r_dto <= dist_mem[rd_addr];
        end
        if (r_state == ST_ORD) begin
            r_pout <= pred_mem[r_vidx[VA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_acc && i_item.action == ACT_RUN) n_state = ST_CLEAR;
            ST_CLEAR:    n_state = ST_PASS_END;
            ST_PASS_END: n_state = pass_done ? ST_ORD : ST_EREAD;
            ST_EREAD:    n_state = ST_FETCH;
            ST_FETCH:    n_state = ST_RELAX;
            ST_RELAX: begin
                if (cyc_hit) begin
                    n_state = ST_CYC_OUT;
                end else if (r_eidx + EW'(1) < r_total) begin
                    n_state = ST_EREAD;
                end else begin
                    n_state = ST_PASS_END;
                end
            end
            ST_CYC_OUT:  if (!i_stall) n_state = ST_IDLE;
            ST_ORD:      n_state = ST_OSEND;
            ST_OSEND: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = last_vtx ? ST_IDLE : ST_ORD;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_vcount <= 7'd4;
            r_source <= 6'd0;
            r_ovalid <= 1'b0;
            r_reached <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_VCOUNT) r_vcount <= i_cfg_data;
                else                           r_source <= i_cfg_data[5:0];
            end
            if (app_acc) begin
                r_total <= r_total + EW'(1);
            end else if (in_acc && i_item.action == ACT_CLEAR) begin
                r_total <= '0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_vidx <= '0;
                    r_n    <= n_eff;
                end
                ST_CLEAR: begin
                    // Clear every reach mark and mark only an in-range source.
                    r_reached <= src_ok ? ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << r_source)
                                        : '0;
                    r_pass    <= '0;
                    r_changed <= 1'b1;
                    r_check   <= 1'b0;
                end
                ST_PASS_END: begin
                    r_eidx <= '0;
                    r_vidx <= '0;
                    if (!pass_done) begin
                        r_changed <= 1'b0;
                        // Up to n-1 relaxation passes, then one check pass.
                        if (r_pass + 7'd1 < r_n) begin
                            r_pass <= r_pass + 7'd1;
                        end else begin
                            r_check <= 1'b1;
                        end
                    end
                end
                ST_EREAD: ;
                ST_FETCH: ;
                ST_RELAX: begin
                    if (rx.update) begin
                        r_reached[e_to[VA-1:0]] <= 1'b1;
                        r_changed <= 1'b1;
                    end
                    r_eidx <= r_eidx + EW'(1);
                end
                ST_CYC_OUT: ;
                ST_ORD: ;
                ST_OSEND: begin
                    if (!r_ovalid || !i_stall) begin
                        r_vidx <= r_vidx + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register: the cycle report or one vertex of the sweep.
    always_ff @(posedge i_clk) begin
        if (cyc_hit) begin
            r_out <= '{vertex: '0, distance: '0, predecessor: NONE_PRED,
                       reachable: 1'b0, status: 1'b1,
                       cycle_edge: 8'(r_eidx), last: 1'b1};
        end else if (r_state == ST_OSEND && (!r_ovalid || !i_stall)) begin
            r_out <= '{vertex: r_vidx[5:0],
                       distance: r_reached[r_vidx[VA-1:0]] ? r_dto : '0,
                       predecessor: r_reached[r_vidx[VA-1:0]] ? r_pout : NONE_PRED,
                       reachable: r_reached[r_vidx[VA-1:0]],
                       status: 1'b0, cycle_edge: '0,
                       last: last_vtx};
        end
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= EW'(MAX_EDGES))
        else $error("edge count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled result beat changed");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_ovalid)
        else $error("result during clear");
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == ST_IDLE))
        else $error("beat taken while busy");
endmodule
`default_nettype wire
